// ===== rtl/ffba_pkg.sv =====
`timescale 1ns / 1ps

package ffba_pkg;

  // Default geometry
  localparam int FFBA_POOL_UNITS = 1024;
  localparam int FFBA_UNIT_BYTES = 64;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_UNITS = 2'd1;
  localparam logic [10:0] POOL_UNITS_RST = 11'd1024;

  // Field widths fixed by the interface
  localparam int SIZE_W = 24;
  localparam int NEED_W = SIZE_W + 1;
  localparam logic [16:0] FREE_BYTES_MAX = 17'h1FFFF;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_SPLIT,
    S_FCHK,
    S_FNEXT,
    S_FPREV,
    S_FDROP,
    S_DONE
  } state_t;

endpackage

// ===== rtl/first_fit_block_allocator_core.sv =====
`timescale 1ns / 1ps

// First-fit block allocator over a pool of fixed-size units (UNIT_BYTES, a power of two).
// Input channel (in_valid/in_ready): op 0 allocates size_bytes, op 1 frees block_addr.
// Output channel (out_valid/out_ready): one beat per input beat with ok, payload_addr
// and free_bytes, the free payload bytes left after the operation.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 = pool_base,
// index 1 = pool_units; a write to either re-initializes the pool to one free block.
// Block headers live in two single-port-read memories (flags+length, previous length)
// with a registered read.
// An allocate walks the blocks first-fit, one header read per cycle, and writes the
// header of the first free block that fits, then the remainder's header when the block
// is split. A free reads the header of the block, its next neighbor and its previous
// neighbor, then writes back. A zero size, a null, misaligned or out-of-pool address,
// or a tiny pool goes straight to the result; a free of a unit that is not an allocated
// block's header fails once that header is read.
// Reset and every config write start a clearing pass that zeroes all headers; no input
// beat is taken during it.
// A result sits in an output register; if the receiver stalls, the block holds the next
// result in its final state until the register frees and takes no new beat meanwhile.
module first_fit_block_allocator_core
  import ffba_pkg::*;
#(
  parameter int POOL_UNITS = FFBA_POOL_UNITS,
  parameter int UNIT_BYTES = FFBA_UNIT_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [SIZE_W-1:0]    size_bytes,
  input  logic [31:0]          block_addr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 ok,
  output logic [31:0]          payload_addr,
  output logic [16:0]          free_bytes,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int UW = $clog2(POOL_UNITS);
  localparam int LW = $clog2(POOL_UNITS + 1);
  localparam int PW = LW + 1;
  localparam int SH = $clog2(UNIT_BYTES);
  localparam int AW = LW + 2;

  // Header memories
  logic [AW-1:0] mem_a [POOL_UNITS];
  logic [LW-1:0] mem_b [POOL_UNITS];
  logic [AW-1:0] rd_a;
  logic [LW-1:0] rd_b;
  logic [UW-1:0] rd_addr;
  logic          wa_en, wb_en;
  logic [UW-1:0] wa_addr, wb_addr;
  logic [AW-1:0] wa_data;
  logic [LW-1:0] wb_data;

  // Registers
  state_t        state, state_next;
  logic [31:0]   pool_base;
  logic [10:0]   pool_units;
  logic [UW-1:0] clr_cnt, clr_cnt_next;
  logic [PW-1:0] pos, pos_next;
  logic [NEED_W-1:0] need, need_next;
  logic [UW-1:0] fu, fu_next;
  logic [LW-1:0] flen, flen_next;
  logic [LW-1:0] fprev, fprev_next;
  logic [LW-1:0] curlen, curlen_next;
  logic [PW-1:0] nx, nx_next;
  logic          nx_ok, nx_ok_next;
  logic          pcond, pcond_next;
  logic [UW-1:0] pp, pp_next;
  logic [LW-1:0] free_units, free_units_next;
  logic          res_ok, res_ok_next;
  logic [31:0]   res_addr, res_addr_next;

  // Derived values
  logic [LW-1:0] n_eff;
  logic [PW-1:0] n_p;
  logic          n_ge2;
  logic [31:0]   base, off, idx;
  logic          fa_ok;
  logic [NEED_W-1:0] need_c;
  logic          rd_start, rd_free;
  logic [LW-1:0] rd_len;
  logic [PW-1:0] next_pos;
  logic          fit, split;
  logic [LW-1:0] need_l;
  logic [31:0]   alloc_addr;
  logic          merge_n, merge_p;
  logic [LW-1:0] curlen_c, newlen;
  logic [PW-1:0] nn_p, nn_u, s_pos, after_pos;
  logic [31:0]   fb32;
  logic          cfg_hit;

  assign n_eff = (32'(pool_units) > 32'(POOL_UNITS)) ? LW'(POOL_UNITS) : LW'(pool_units);
  assign n_p   = PW'(n_eff);
  assign n_ge2 = n_eff >= LW'(2);
  assign base  = pool_base & ~(32'(UNIT_BYTES) - 32'd1);
  assign off   = block_addr - base;
  assign idx   = off >> SH;
  assign fa_ok = (block_addr != 32'd0) && n_ge2 && (off[SH-1:0] == '0)
                 && (idx != 32'd0) && (idx <= 32'(n_eff));
  assign need_c = ((NEED_W'(size_bytes) + NEED_W'(UNIT_BYTES - 1)) >> SH) + NEED_W'(1);

  assign rd_start = rd_a[AW-1];
  assign rd_free  = rd_a[AW-2];
  assign rd_len   = rd_a[LW-1:0];
  assign next_pos = pos + PW'(rd_len);
  assign fit      = rd_free && (NEED_W'(rd_len) >= need);
  assign split    = (NEED_W'(rd_len) >= need + NEED_W'(2));
  assign need_l   = LW'(need);
  assign alloc_addr = base + ((32'(pos) + 32'd1) << SH);
  assign s_pos    = pos + PW'(need_l);
  assign after_pos = pos + PW'(flen);

  assign merge_n  = nx_ok && rd_start && rd_free;
  assign curlen_c = flen + (merge_n ? rd_len : LW'(0));
  assign merge_p  = pcond && rd_start && rd_free;
  assign newlen   = rd_len + curlen;
  assign nn_p     = PW'(pp) + PW'(newlen);
  assign nn_u     = PW'(fu) + PW'(curlen);

  assign fb32 = 32'(free_units) << SH;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     ((cfg_index == REG_POOL_BASE) || (cfg_index == REG_POOL_UNITS));

  // Header memories: one write port each, shared registered read
  always_ff @(posedge clk) begin
    if (wa_en) mem_a[wa_addr] <= wa_data;
    if (wb_en) mem_b[wb_addr] <= wb_data;
    rd_a <= mem_a[rd_addr];
    rd_b <= mem_b[rd_addr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // Next state, memory control and datapath updates
  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    pos_next        = pos;
    need_next       = need;
    fu_next         = fu;
    flen_next       = flen;
    fprev_next      = fprev;
    curlen_next     = curlen;
    nx_next         = nx;
    nx_ok_next      = nx_ok;
    pcond_next      = pcond;
    pp_next         = pp;
    free_units_next = free_units;
    res_ok_next     = res_ok;
    res_addr_next   = res_addr;
    rd_addr = '0;
    wa_en   = 1'b0;
    wa_addr = '0;
    wa_data = '0;
    wb_en   = 1'b0;
    wb_addr = '0;
    wb_data = '0;

    unique case (state)
      S_CLEAR: begin
        wa_en   = 1'b1;
        wa_addr = clr_cnt;
        wb_en   = 1'b1;
        wb_addr = clr_cnt;
        clr_cnt_next = clr_cnt + UW'(1);
        if (clr_cnt == UW'(POOL_UNITS - 1)) state_next = S_INIT;
      end
      S_INIT: begin
        if (n_ge2) begin
          wa_en   = 1'b1;
          wa_data = {1'b1, 1'b1, n_eff};
          free_units_next = n_eff - LW'(1);
        end else begin
          free_units_next = '0;
        end
        state_next = S_IDLE;
      end
      S_IDLE: begin
        res_ok_next   = 1'b0;
        res_addr_next = '0;
        if (op) rd_addr = UW'(idx - 32'd1);
        if (in_valid) begin
          if (!op) begin
            need_next = need_c;
            pos_next  = '0;
            if (size_bytes == '0 || !n_ge2) state_next = S_DONE;
            else                             state_next = S_ALLOC;
          end else begin
            fu_next = UW'(idx - 32'd1);
            if (fa_ok) state_next = S_FCHK;
            else       state_next = S_DONE;
          end
        end
      end
      // First-fit walk: one header per cycle
      S_ALLOC: begin
        if (rd_len == '0) begin
          state_next = S_DONE;
        end else if (fit) begin
          wa_en   = 1'b1;
          wa_addr = UW'(pos);
          res_ok_next   = 1'b1;
          res_addr_next = alloc_addr;
          flen_next = rd_len;
          if (split) begin
            wa_data = {1'b1, 1'b0, need_l};
            wb_en   = 1'b1;
            wb_addr = UW'(s_pos);
            wb_data = need_l;
            free_units_next = free_units - need_l;
            state_next = S_SPLIT;
          end else begin
            wa_data = {1'b1, 1'b0, rd_len};
            free_units_next = free_units - (rd_len - LW'(1));
            state_next = S_DONE;
          end
        end else if (next_pos >= n_p) begin
          state_next = S_DONE;
        end else begin
          rd_addr  = UW'(next_pos);
          pos_next = next_pos;
        end
        if (state_next == S_ALLOC && !(next_pos < n_p && !fit && rd_len != '0)) begin
          rd_addr = UW'(pos);
        end
      end
      // Remainder becomes a free block
      S_SPLIT: begin
        wa_en   = 1'b1;
        wa_addr = UW'(s_pos);
        wa_data = {1'b1, 1'b1, flen - need_l};
        if (after_pos < n_p) begin
          wb_en   = 1'b1;
          wb_addr = UW'(after_pos);
          wb_data = flen - need_l;
        end
        state_next = S_DONE;
      end
      // Header of the block being freed
      S_FCHK: begin
        if (!rd_start || rd_free) begin
          state_next = S_DONE;
        end else begin
          flen_next  = rd_len;
          fprev_next = rd_b;
          free_units_next = free_units + (rd_len - LW'(1));
          nx_next    = PW'(fu) + PW'(rd_len);
          nx_ok_next = (PW'(fu) + PW'(rd_len)) < n_p;
          rd_addr    = UW'(PW'(fu) + PW'(rd_len));
          state_next = S_FNEXT;
        end
      end
      // Merge with the next neighbor, fetch the previous one
      S_FNEXT: begin
        curlen_next = curlen_c;
        if (merge_n) begin
          wa_en   = 1'b1;
          wa_addr = UW'(nx);
          wb_en   = 1'b1;
          wb_addr = UW'(nx);
          free_units_next = free_units + LW'(1);
        end
        pcond_next = (fu != '0) && (fprev != '0) && (PW'(fprev) <= PW'(fu));
        pp_next    = UW'(PW'(fu) - PW'(fprev));
        rd_addr    = UW'(PW'(fu) - PW'(fprev));
        state_next = S_FPREV;
      end
      // Merge with the previous neighbor or write the block back free
      S_FPREV: begin
        wa_en = 1'b1;
        res_ok_next = 1'b1;
        if (merge_p) begin
          wa_addr = pp;
          wa_data = {1'b1, 1'b1, newlen};
          if (nn_p < n_p) begin
            wb_en   = 1'b1;
            wb_addr = UW'(nn_p);
            wb_data = newlen;
          end
          free_units_next = free_units + LW'(1);
          state_next = S_FDROP;
        end else begin
          wa_addr = fu;
          wa_data = {1'b1, 1'b1, curlen};
          if (nn_u < n_p) begin
            wb_en   = 1'b1;
            wb_addr = UW'(nn_u);
            wb_data = curlen;
          end
          state_next = S_DONE;
        end
      end
      S_FDROP: begin
        wa_en   = 1'b1;
        wa_addr = fu;
        wb_en   = 1'b1;
        wb_addr = fu;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase

    // Config write restarts the pool
    if (cfg_hit) begin
      state_next   = S_CLEAR;
      clr_cnt_next = '0;
    end
  end

  // Datapath and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      pool_units <= POOL_UNITS_RST;
      clr_cnt    <= '0;
      free_units <= '0;
    end else begin
      clr_cnt    <= clr_cnt_next;
      free_units <= free_units_next;
      if (cfg_valid && cfg_ready && cfg_index == REG_POOL_BASE)  pool_base  <= cfg_data;
      if (cfg_valid && cfg_ready && cfg_index == REG_POOL_UNITS) pool_units <= cfg_data[10:0];
    end
    pos      <= pos_next;
    need     <= need_next;
    fu       <= fu_next;
    flen     <= flen_next;
    fprev    <= fprev_next;
    curlen   <= curlen_next;
    nx       <= nx_next;
    nx_ok    <= nx_ok_next;
    pcond    <= pcond_next;
    pp       <= pp_next;
    res_ok   <= res_ok_next;
    res_addr <= res_addr_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      ok           <= res_ok;
      payload_addr <= res_addr;
      free_bytes   <= (fb32 > 32'(FREE_BYTES_MAX)) ? FREE_BYTES_MAX : fb32[16:0];
    end
  end

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR || state == S_INIT) |-> !in_ready)
    else $error("input taken during pool clear");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (payload_addr == 32'd0))
    else $error("failed result carries an address");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((free_units == '0) || (free_units < n_eff)))
    else $error("free unit count exceeds pool");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result beat without a finished operation");
`endif

endmodule
